// File: sv/lsee_pkg.sv
// lsee_pkg: shared constants and types of the log-structured eeprom emulation core
// no dependencies
package lsee_pkg;

  localparam int PAGE_WORDS = 1024;
  localparam int PAGE_AW    = $clog2(PAGE_WORDS);
  localparam int MEM_AW     = PAGE_AW + 1;
  localparam int TAIL_W     = PAGE_AW + 1;
  localparam int CELL_COUNT = 3072;
  localparam int MAP_SPAN   = (CELL_COUNT + 3) / 4;
  localparam int MAPW_W     = 10;
  localparam int IDX_W      = 12;
  localparam int RB_W       = 12;
  localparam int ADDR_POS   = 20;
  localparam int BITMAP_POS = 8;

  localparam logic [7:0]  BYTE_ERASED = 8'hff;
  localparam logic [31:0] WORD_ERASED = 32'hffff_ffff;

  // command handed from the front to the back
  typedef struct packed {
    logic             is_write;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [7:0]       val;
  } cmd_t;

  // engine status watched at the top level
  typedef struct packed {
    logic [TAIL_W-1:0] tail;
    logic [MAPW_W-1:0] map_words;
  } stat_t;

endpackage

// File: sv/lsee_if.sv
// lsee_in_if / lsee_out_if: valid-ready channels of the core
// depends on nothing
interface lsee_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [11:0] cell_index;
  logic [7:0]  write_byte;
  modport source (output valid, mode, cell_index, write_byte, input ready);
  modport sink   (input valid, mode, cell_index, write_byte, output ready);
endinterface

interface lsee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       logged;
  logic       compacted;
  modport source (output valid, read_byte, logged, compacted, input ready);
  modport sink   (input valid, read_byte, logged, compacted, output ready);
endinterface

// File: sv/lsee_front.sv
// lsee_front: accepts items, classifies them and queues them for the engine
// depends on lsee_pkg, lsee_if
module lsee_front (
  input  logic               clk,
  input  logic               rst_n,
  lsee_in_if.sink            in_ch,
  output logic               cmd_valid,
  output lsee_pkg::cmd_t     cmd,
  input  logic               cmd_ready
);

  lsee_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;
  lsee_pkg::cmd_t cls;

  // classify the incoming item
  always_comb begin
    cls.is_write = in_ch.mode;
    cls.in_range = (32'(in_ch.cell_index) < lsee_pkg::CELL_COUNT);
    cls.idx      = in_ch.cell_index;
    cls.val      = in_ch.write_byte;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: sv/lsee_back.sv
// lsee_back: lookup, append and compaction engine with the two-page flash store
// depends on lsee_pkg, lsee_if
module lsee_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  lsee_pkg::cmd_t     cmd,
  output logic               cmd_ready,
  lsee_out_if.source         out_ch,
  output lsee_pkg::stat_t    stat
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_SCAN = 16'h0002, S_SCHK = 16'h0004, S_MAP  = 16'h0008,
    S_MCHK = 16'h0010, S_DEC  = 16'h0020, S_APP  = 16'h0040, S_OUT  = 16'h0080,
    S_CPR  = 16'h0100, S_CPW  = 16'h0200, S_RPR  = 16'h0400, S_RPL  = 16'h0800,
    S_RPM  = 16'h1000, S_SCR  = 16'h2000, S_SCC  = 16'h4000, S_SWP  = 16'h8000
  } state_t;

  localparam int AW = lsee_pkg::MEM_AW;
  localparam int PW = lsee_pkg::PAGE_AW;
  localparam int TW = lsee_pkg::TAIL_W;
  localparam int MW = lsee_pkg::MAPW_W;

  logic [31:0] mem_r [2*lsee_pkg::PAGE_WORDS];
  logic [31:0] rd_r;

  state_t                   state_r, state_nxt;
  lsee_pkg::cmd_t           cmd_r, cmd_nxt;
  logic [TW-1:0]            pos_r, pos_nxt;
  logic [7:0]               old_r, old_nxt;
  logic [MW-1:0]            cnt_r, cnt_nxt;
  logic [MW-1:0]            len_r, len_nxt;
  logic [31:0]              lw_r, lw_nxt;
  logic                     page_r, page_nxt;
  logic [MW-1:0]            mapw_r, mapw_nxt;
  logic [TW-1:0]            tail_r, tail_nxt;
  logic [lsee_pkg::RB_W-1:0] rb_r, rb_nxt;
  logic                     logged_r, logged_nxt;
  logic                     comp_r, comp_nxt;

  logic [AW-1:0]            raddr, waddr;
  logic                     we;
  logic [31:0]              wdata;
  logic [TW-1:0]            start;
  logic [TW-1:0]            maddr;
  logic [lsee_pkg::RB_W-1:0] rbit;
  logic [PW-1:0]            lw_maddr;
  logic [PW-1:0]            rd_maddr;
  logic [7:0]               map_byte;
  logic [31:0]              merged;

  assign start    = TW'(mapw_r) + TW'(1);
  assign maddr    = TW'(cmd_r.idx >> 2) + TW'(1);
  assign rbit     = lsee_pkg::RB_W'(1) << cmd_r.idx[11:8];
  assign lw_maddr = PW'(lw_r[31:22]) + PW'(1);
  assign rd_maddr = PW'(rd_r[31:22]) + PW'(1);

  // byte of a map word for the current cell
  always_comb begin
    case (cmd_r.idx[1:0])
      2'd0:    map_byte = rd_r[7:0];
      2'd1:    map_byte = rd_r[15:8];
      2'd2:    map_byte = rd_r[23:16];
      default: map_byte = rd_r[31:24];
    endcase
  end

  // replay merge: log value into its map byte
  always_comb begin
    merged = rd_r;
    for (int k = 0; k < 4; k++) begin
      if (lw_r[21:20] == 2'(k)) begin
        merged[k*8 +: 8] = lw_r[7:0];
      end
    end
  end

  // engine sequencer
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    pos_nxt    = pos_r;
    old_nxt    = old_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    lw_nxt     = lw_r;
    page_nxt   = page_r;
    mapw_nxt   = mapw_r;
    tail_nxt   = tail_r;
    rb_nxt     = rb_r;
    logged_nxt = logged_r;
    comp_nxt   = comp_r;
    raddr      = '0;
    waddr      = '0;
    wdata      = '0;
    we         = 1'b0;
    cmd_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt    = cmd;
          pos_nxt    = tail_r;
          logged_nxt = 1'b0;
          comp_nxt   = 1'b0;
          old_nxt    = lsee_pkg::BYTE_ERASED;
          state_nxt  = cmd.in_range ? S_SCAN : S_DEC;
        end
      end
      // walk the log newest first
      S_SCAN: begin
        if (pos_r > start) begin
          raddr     = {page_r, PW'(pos_r - TW'(1))};
          pos_nxt   = pos_r - TW'(1);
          state_nxt = S_SCHK;
        end else begin
          state_nxt = S_MAP;
        end
      end
      S_SCHK: begin
        if ((rd_r[19:8] & rbit) == '0) begin
          state_nxt = S_MAP;
        end else if (rd_r[31:20] == cmd_r.idx) begin
          old_nxt   = rd_r[7:0];
          state_nxt = S_DEC;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      // fall back to the packed map
      S_MAP: begin
        if (maddr < start) begin
          raddr     = {page_r, PW'(maddr)};
          state_nxt = S_MCHK;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_MCHK: begin
        old_nxt   = map_byte;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (cmd_r.is_write && cmd_r.in_range && cmd_r.val != old_r) begin
          if (32'(tail_r) >= lsee_pkg::PAGE_WORDS) begin
            cnt_nxt   = MW'(1);
            comp_nxt  = 1'b1;
            state_nxt = S_CPR;
          end else begin
            state_nxt = S_APP;
          end
        end else begin
          state_nxt = S_OUT;
        end
      end
      // append the log word
      S_APP: begin
        we         = 1'b1;
        waddr      = {page_r, PW'(tail_r)};
        wdata      = {cmd_r.idx, rb_r | rbit, cmd_r.val};
        rb_nxt     = rb_r | rbit;
        tail_nxt   = tail_r + TW'(1);
        logged_nxt = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      // compaction: copy the old map, erased beyond it
      S_CPR: begin
        raddr     = {page_r, PW'(cnt_r)};
        state_nxt = S_CPW;
      end
      S_CPW: begin
        we      = 1'b1;
        waddr   = {~page_r, PW'(cnt_r)};
        wdata   = (TW'(cnt_r) < start) ? rd_r : lsee_pkg::WORD_ERASED;
        cnt_nxt = cnt_r + MW'(1);
        if (32'(cnt_r) == lsee_pkg::MAP_SPAN) begin
          pos_nxt   = start;
          state_nxt = S_RPR;
        end else begin
          state_nxt = S_CPR;
        end
      end
      // compaction: replay the log oldest first
      S_RPR: begin
        if (pos_r < tail_r) begin
          raddr     = {page_r, PW'(pos_r)};
          state_nxt = S_RPL;
        end else begin
          cnt_nxt   = MW'(1);
          len_nxt   = '0;
          state_nxt = S_SCR;
        end
      end
      S_RPL: begin
        lw_nxt    = rd_r;
        raddr     = {~page_r, rd_maddr};
        state_nxt = S_RPM;
      end
      S_RPM: begin
        we        = 1'b1;
        waddr     = {~page_r, lw_maddr};
        wdata     = merged;
        pos_nxt   = pos_r + TW'(1);
        state_nxt = S_RPR;
      end
      // compaction: find the map length
      S_SCR: begin
        raddr     = {~page_r, PW'(cnt_r)};
        state_nxt = S_SCC;
      end
      S_SCC: begin
        if (rd_r != lsee_pkg::WORD_ERASED) begin
          len_nxt = cnt_r;
        end
        cnt_nxt = cnt_r + MW'(1);
        if (32'(cnt_r) == lsee_pkg::MAP_SPAN) begin
          state_nxt = S_SWP;
        end else begin
          state_nxt = S_SCR;
        end
      end
      S_SWP: begin
        we        = 1'b1;
        waddr     = {~page_r, PW'(0)};
        wdata     = 32'(len_r);
        page_nxt  = ~page_r;
        mapw_nxt  = len_r;
        tail_nxt  = TW'(len_r) + TW'(1);
        rb_nxt    = '0;
        state_nxt = S_APP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      page_r  <= 1'b0;
      mapw_r  <= '0;
      tail_r  <= TW'(1);
      rb_r    <= '0;
    end else begin
      state_r <= state_nxt;
      page_r  <= page_nxt;
      mapw_r  <= mapw_nxt;
      tail_r  <= tail_nxt;
      rb_r    <= rb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    pos_r    <= pos_nxt;
    old_r    <= old_nxt;
    cnt_r    <= cnt_nxt;
    len_r    <= len_nxt;
    lw_r     <= lw_nxt;
    logged_r <= logged_nxt;
    comp_r   <= comp_nxt;
  end

  // flash store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_r <= mem_r[raddr];
  end

  assign out_ch.valid     = (state_r == S_OUT);
  assign out_ch.read_byte = old_r;
  assign out_ch.logged    = logged_r;
  assign out_ch.compacted = comp_r;

  assign stat.tail      = tail_r;
  assign stat.map_words = mapw_r;

endmodule

// File: sv/log_structured_eeprom_emulation_core.sv
// log_structured_eeprom_emulation_core: top level, front queue plus engine
// depends on lsee_pkg, lsee_if, lsee_front, lsee_back
//
// Emulates 3072 byte cells on two 1024-word flash pages held in one memory
// with a single read and a single write port. Items enter a two-deep queue,
// so the input keeps taking items while a result waits. A read walks the log
// newest first, one memory read per log word (at most the log length, less
// when the range bitmap stops the walk early). A write that changes the
// value also appends a log word. A write on a full page first compacts: it
// copies the 768-word map area, replays the log into the other page, and
// then finds the new map length. One result follows each item, in order.
module log_structured_eeprom_emulation_core (
  input  logic         clk,
  input  logic         rst_n,
  lsee_in_if.sink      in_ch,
  lsee_out_if.source   out_ch
);

  logic            cmd_valid;
  logic            cmd_ready;
  lsee_pkg::cmd_t  cmd;
  lsee_pkg::stat_t stat;

  lsee_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  lsee_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch),
    .stat      (stat)
  );

  // a page switch always comes with an append
  a_comp_logs: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.compacted |-> out_ch.logged)
    else $error("compaction without append");

  // the log tail never runs past the page
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stat.tail) <= lsee_pkg::PAGE_WORDS)
    else $error("log tail beyond page");

  // the log always starts after the map
  a_tail_map: assert property (@(posedge clk) disable iff (!rst_n)
    stat.tail > lsee_pkg::TAIL_W'(stat.map_words))
    else $error("log tail inside map");

endmodule
